### hdl/spsp_pkg.sv
package spsp_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int COST_BITS = 16;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int EDGE_AW   = $clog2(MAX_EDGES);
    localparam int EPTR_W    = EDGE_AW + 1;
    localparam int CNT_W     = NODE_AW + 1;
    localparam int DIST_W    = 32;

    localparam logic [DIST_W-1:0] UNREACHED_DISTANCE = 32'h3f3f3f3f;
    localparam logic [DIST_W-1:0] DIST_MAX           = '1;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [NODE_AW-1:0]   target;
        logic [COST_BITS-1:0] weight;
        logic [EPTR_W-1:0]    link;
    } edge_t;

    typedef struct packed {
        logic              reached;
        logic              done;
        logic [DIST_W-1:0] path_cost;
    } node_t;

    typedef struct packed {
        logic [NODE_AW-1:0] raddr;
        logic               we;
        logic [NODE_AW-1:0] waddr;
        logic [EPTR_W-1:0]  wdata;
    } head_req_t;

    typedef struct packed {
        logic [EDGE_AW-1:0] raddr;
        logic               we;
        logic [EDGE_AW-1:0] waddr;
        edge_t              wdata;
    } edge_req_t;

    typedef struct packed {
        logic [NODE_AW-1:0] raddr;
        logic               we;
        logic [NODE_AW-1:0] waddr;
        node_t              wdata;
    } node_req_t;

endpackage

### hdl/spsp_if.sv
interface spsp_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [spsp_pkg::NODE_AW-1:0]  from_node;
    logic [spsp_pkg::NODE_AW-1:0]  to_node;
    logic [15:0]                   edge_cost;

    modport source (output valid, action, from_node, to_node, edge_cost, input ready);
    modport sink   (input valid, action, from_node, to_node, edge_cost, output ready);
endinterface

interface spsp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spsp_pkg::DIST_W-1:0]   distance;
    logic                          reachable;
    logic                          edge_store_full;

    modport source (output valid, distance, reachable, edge_store_full, input ready);
    modport sink   (input valid, distance, reachable, edge_store_full, output ready);
endinterface

interface spsp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [spsp_pkg::CNT_W-1:0]    node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

### hdl/spsp_graph_store.sv
module spsp_graph_store (
    input  logic                        clk,
    input  spsp_pkg::head_req_t         head_req,
    output logic [spsp_pkg::EPTR_W-1:0] head_rdata,
    input  spsp_pkg::edge_req_t         edge_req,
    output spsp_pkg::edge_t             edge_rdata
);

    logic [spsp_pkg::EPTR_W-1:0] head_mem [spsp_pkg::MAX_NODES];
    spsp_pkg::edge_t             edge_mem [spsp_pkg::MAX_EDGES];

    always_ff @(posedge clk)
    begin
        if (head_req.we)
        begin
            head_mem[head_req.waddr] <= head_req.wdata;
        end
        head_rdata <= head_mem[head_req.raddr];
    end

    always_ff @(posedge clk)
    begin
        if (edge_req.we)
        begin
            edge_mem[edge_req.waddr] <= edge_req.wdata;
        end
        edge_rdata <= edge_mem[edge_req.raddr];
    end

endmodule

### hdl/spsp_node_table.sv
module spsp_node_table (
    input  logic                clk,
    input  spsp_pkg::node_req_t node_req,
    output spsp_pkg::node_t     node_rdata
);

    spsp_pkg::node_t node_mem [spsp_pkg::MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (node_req.we)
        begin
            node_mem[node_req.waddr] <= node_req.wdata;
        end
        node_rdata <= node_mem[node_req.raddr];
    end

endmodule

### hdl/single_pair_shortest_path.sv
// clear: list heads swept one per cycle; add edge: the edge and its list head are written together (not if dropped)
// query: the node table is cleared and the source marked, then nodes are settled in turn and their edges walked;
//   each settle step scans the node table once through its single read port
// one item in work at a time; a new item is taken while a result waits in the output register
// reset (rst_n low, async) clears control state, then every list head is swept
//   with no item accepted; configuration writes are taken throughout
module single_pair_shortest_path (
    input  logic       clk,
    input  logic       rst_n,
    spsp_cfg_if.sink   cfg,
    spsp_req_if.sink   req,
    spsp_rsp_if.source rsp
);

    localparam logic [4:0] S_HCLR    = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_ADD_WR  = 5'd2;
    localparam logic [4:0] S_QCLR    = 5'd3;
    localparam logic [4:0] S_QSRC    = 5'd4;
    localparam logic [4:0] S_SCAN    = 5'd5;
    localparam logic [4:0] S_SCAN_END = 5'd6;
    localparam logic [4:0] S_SETTLE  = 5'd7;
    localparam logic [4:0] S_HEAD    = 5'd8;
    localparam logic [4:0] S_EDGE    = 5'd9;
    localparam logic [4:0] S_EDGE_W  = 5'd10;
    localparam logic [4:0] S_NODE_W  = 5'd11;
    localparam logic [4:0] S_RES_RD  = 5'd12;
    localparam logic [4:0] S_RES     = 5'd13;
    localparam logic [4:0] S_OUT     = 5'd14;

    logic [4:0]                           state_reg, state_next;
    logic [spsp_pkg::CNT_W-1:0]           n_reg;
    logic [spsp_pkg::EPTR_W-1:0]          total_reg;
    logic                                 overflow_reg;
    logic [spsp_pkg::NODE_AW-1:0]         idx_reg;
    logic [spsp_pkg::NODE_AW-1:0]         rd_idx_reg;
    logic                                 rd_vld_reg;
    logic                                 found_reg;
    logic [spsp_pkg::NODE_AW-1:0]         u_reg;
    logic [spsp_pkg::DIST_W-1:0]          best_reg;
    logic [spsp_pkg::NODE_AW-1:0]         from_reg;
    logic [spsp_pkg::NODE_AW-1:0]         to_reg;
    logic [spsp_pkg::COST_BITS-1:0]       cost_reg;
    logic [spsp_pkg::EPTR_W-1:0]          e_reg;
    logic [spsp_pkg::NODE_AW-1:0]         tgt_reg;
    logic [spsp_pkg::COST_BITS-1:0]       w_reg;
    logic [spsp_pkg::EPTR_W-1:0]          link_reg;
    logic [spsp_pkg::DIST_W-1:0]          res_dist_reg;
    logic                                 res_ok_reg;
    logic                                 out_vld_reg;
    logic [spsp_pkg::DIST_W-1:0]          out_dist_reg;
    logic                                 out_ok_reg;
    logic                                 out_full_reg;

    spsp_pkg::head_req_t                  head_req;
    logic [spsp_pkg::EPTR_W-1:0]          head_rdata;
    spsp_pkg::edge_req_t                  edge_req;
    spsp_pkg::edge_t                      edge_rdata;
    spsp_pkg::node_req_t                  node_req;
    spsp_pkg::node_t                      node_rdata;

    logic                                 req_fire;
    logic                                 ends_ok;
    logic                                 idx_last;
    logic                                 cand;
    logic [spsp_pkg::DIST_W:0]            sum;
    logic [spsp_pkg::DIST_W-1:0]          relax_d;
    logic                                 out_free;

    spsp_graph_store u_graph (
        .clk        (clk),
        .head_req   (head_req),
        .head_rdata (head_rdata),
        .edge_req   (edge_req),
        .edge_rdata (edge_rdata)
    );

    spsp_node_table u_nodes (
        .clk        (clk),
        .node_req   (node_req),
        .node_rdata (node_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign ends_ok   = ({1'b0, req.from_node} < n_reg) && ({1'b0, req.to_node} < n_reg);
    assign idx_last  = ({1'b0, idx_reg} == (n_reg - spsp_pkg::CNT_W'(1)));
    assign out_free  = !out_vld_reg || rsp.ready;

    // scan candidate: reached, not settled, strictly smaller keeps the lowest index on ties
    assign cand = rd_vld_reg && node_rdata.reached && !node_rdata.done
                  && (!found_reg || node_rdata.path_cost < best_reg);

    // saturating relax sum
    assign sum     = {1'b0, best_reg} + {{(spsp_pkg::DIST_W + 1 - spsp_pkg::COST_BITS){1'b0}}, w_reg};
    assign relax_d = sum[spsp_pkg::DIST_W] ? spsp_pkg::DIST_MAX : sum[spsp_pkg::DIST_W-1:0];

    always_comb
    begin
        head_req = '0;
        edge_req = '0;
        node_req = '0;
        case (state_reg)
            S_HCLR:
            begin
                head_req.we    = 1'b1;
                head_req.waddr = idx_reg;
                head_req.wdata = spsp_pkg::EPTR_W'(spsp_pkg::MAX_EDGES);
            end
            S_IDLE:
            begin
                head_req.raddr = req.from_node;
            end
            S_ADD_WR:
            begin
                head_req.we          = 1'b1;
                head_req.waddr       = from_reg;
                head_req.wdata       = total_reg;
                edge_req.we          = 1'b1;
                edge_req.waddr       = total_reg[spsp_pkg::EDGE_AW-1:0];
                edge_req.wdata.target = to_reg;
                edge_req.wdata.weight = cost_reg;
                edge_req.wdata.link   = head_rdata;
            end
            S_QCLR:
            begin
                node_req.we    = 1'b1;
                node_req.waddr = idx_reg;
            end
            S_QSRC:
            begin
                node_req.we            = 1'b1;
                node_req.waddr         = from_reg;
                node_req.wdata.reached = 1'b1;
            end
            S_SCAN:
            begin
                node_req.raddr = idx_reg;
            end
            S_SETTLE:
            begin
                node_req.we              = 1'b1;
                node_req.waddr           = u_reg;
                node_req.wdata.reached   = 1'b1;
                node_req.wdata.done      = 1'b1;
                node_req.wdata.path_cost = best_reg;
                head_req.raddr           = u_reg;
            end
            S_EDGE:
            begin
                edge_req.raddr = e_reg[spsp_pkg::EDGE_AW-1:0];
            end
            S_EDGE_W:
            begin
                node_req.raddr = edge_rdata.target;
            end
            S_NODE_W:
            begin
                node_req.we              = !node_rdata.done
                                           && (!node_rdata.reached
                                               || relax_d < node_rdata.path_cost);
                node_req.waddr           = tgt_reg;
                node_req.wdata.reached   = 1'b1;
                node_req.wdata.path_cost = relax_d;
            end
            S_RES_RD:
            begin
                node_req.raddr = to_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_HCLR:
            begin
                if (idx_reg == spsp_pkg::NODE_AW'(spsp_pkg::MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.action)
                        spsp_pkg::ACT_CLEAR: state_next = S_HCLR;
                        spsp_pkg::ACT_ADD:
                        begin
                            if (ends_ok && total_reg < spsp_pkg::EPTR_W'(spsp_pkg::MAX_EDGES))
                            begin
                                state_next = S_ADD_WR;
                            end
                        end
                        spsp_pkg::ACT_QUERY: state_next = ends_ok ? S_QCLR : S_OUT;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_WR:   state_next = S_IDLE;
            S_QCLR:     state_next = idx_last ? S_QSRC : S_QCLR;
            S_QSRC:     state_next = S_SCAN;
            S_SCAN:     state_next = idx_last ? S_SCAN_END : S_SCAN;
            S_SCAN_END: state_next = (found_reg || cand) ? S_SETTLE : S_RES_RD;
            S_SETTLE:   state_next = S_HEAD;
            S_HEAD:     state_next = S_EDGE;
            S_EDGE:     state_next = (e_reg < total_reg) ? S_EDGE_W : S_SCAN;
            S_EDGE_W:
            begin
                state_next = ({1'b0, edge_rdata.target} < n_reg) ? S_NODE_W : S_EDGE;
            end
            S_NODE_W:   state_next = S_EDGE;
            S_RES_RD:   state_next = S_RES;
            S_RES:      state_next = S_OUT;
            S_OUT:      state_next = out_free ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_HCLR;
            n_reg        <= spsp_pkg::CNT_W'(spsp_pkg::MAX_NODES);
            total_reg    <= '0;
            overflow_reg <= 1'b0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                if (cfg.node_count == '0)
                begin
                    n_reg <= spsp_pkg::CNT_W'(1);
                end
                else if (cfg.node_count > spsp_pkg::CNT_W'(spsp_pkg::MAX_NODES))
                begin
                    n_reg <= spsp_pkg::CNT_W'(spsp_pkg::MAX_NODES);
                end
                else
                begin
                    n_reg <= cfg.node_count;
                end
            end
            // a beat taken in the output step is refilled there
            if (rsp.valid && rsp.ready && state_reg != S_OUT)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                S_HCLR:
                begin
                    idx_reg <= idx_reg + spsp_pkg::NODE_AW'(1);
                end
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (req_fire)
                    begin
                        if (req.action == spsp_pkg::ACT_CLEAR)
                        begin
                            total_reg    <= '0;
                            overflow_reg <= 1'b0;
                        end
                        if (req.action == spsp_pkg::ACT_ADD && ends_ok
                            && total_reg >= spsp_pkg::EPTR_W'(spsp_pkg::MAX_EDGES))
                        begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                S_ADD_WR:
                begin
                    total_reg <= total_reg + spsp_pkg::EPTR_W'(1);
                end
                S_QCLR:
                begin
                    idx_reg <= idx_last ? '0 : idx_reg + spsp_pkg::NODE_AW'(1);
                end
                S_QSRC:
                begin
                    idx_reg    <= '0;
                    rd_vld_reg <= 1'b0;
                    found_reg  <= 1'b0;
                end
                S_SCAN, S_SCAN_END:
                begin
                    idx_reg    <= idx_reg + spsp_pkg::NODE_AW'(1);
                    rd_vld_reg <= (state_reg == S_SCAN);
                    if (cand)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                S_EDGE:
                begin
                    if (e_reg >= total_reg)
                    begin
                        // next settle step
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        found_reg  <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    out_vld_reg <= out_vld_reg;
                    if (out_free)
                    begin
                        out_vld_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (req_fire)
        begin
            from_reg     <= req.from_node;
            to_reg       <= req.to_node;
            cost_reg     <= req.edge_cost[spsp_pkg::COST_BITS-1:0];
            res_dist_reg <= spsp_pkg::UNREACHED_DISTANCE;
            res_ok_reg   <= 1'b0;
        end
        if ((state_reg == S_SCAN || state_reg == S_SCAN_END) && cand)
        begin
            u_reg    <= rd_idx_reg;
            best_reg <= node_rdata.path_cost;
        end
        if (state_reg == S_HEAD)
        begin
            e_reg <= head_rdata;
        end
        if (state_reg == S_EDGE_W)
        begin
            tgt_reg  <= edge_rdata.target;
            w_reg    <= edge_rdata.weight;
            link_reg <= edge_rdata.link;
            if ({1'b0, edge_rdata.target} >= n_reg)
            begin
                e_reg <= edge_rdata.link;
            end
        end
        if (state_reg == S_NODE_W)
        begin
            e_reg <= link_reg;
        end
        if (state_reg == S_RES)
        begin
            res_ok_reg   <= node_rdata.reached;
            res_dist_reg <= node_rdata.reached ? node_rdata.path_cost
                                               : spsp_pkg::UNREACHED_DISTANCE;
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_dist_reg <= res_dist_reg;
            out_ok_reg   <= res_ok_reg;
            out_full_reg <= overflow_reg;
        end
    end

    assign rsp.valid           = out_vld_reg;
    assign rsp.distance        = out_dist_reg;
    assign rsp.reachable       = out_ok_reg;
    assign rsp.edge_store_full = out_full_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= spsp_pkg::EPTR_W'(spsp_pkg::MAX_EDGES))
        else $error("edge count past store size");

    a_add_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD_WR |=> total_reg == $past(total_reg) + spsp_pkg::EPTR_W'(1))
        else $error("edge add did not advance edge count");

    a_walk_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EDGE_W |-> $past(e_reg) < total_reg)
        else $error("edge walk read past stored edges");

    a_result_needs_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside output step");

endmodule

### bench/spsp_path_checker.sv
module spsp_path_checker (
    input  logic clk,
    input  logic rst_n,
    spsp_cfg_if  cfg,
    spsp_req_if  req,
    spsp_rsp_if  rsp,
    output int   errors,
    output int   pending
);

    typedef struct packed {
        logic [spsp_pkg::DIST_W-1:0] distance;
        logic                        reachable;
        logic                        full;
    } path_answer_t;

    path_answer_t answers[$];

    logic [spsp_pkg::CNT_W-1:0]     nodes_reg;
    int                             first_edge [spsp_pkg::MAX_NODES];
    int                             edge_to    [spsp_pkg::MAX_EDGES];
    logic [spsp_pkg::COST_BITS-1:0] edge_cost_q[spsp_pkg::MAX_EDGES];
    int                             next_edge  [spsp_pkg::MAX_EDGES];
    int                             edges_held;
    bit                             dropped;

    logic [spsp_pkg::DIST_W-1:0] best [spsp_pkg::MAX_NODES];
    bit                          done [spsp_pkg::MAX_NODES];
    bit                          seen [spsp_pkg::MAX_NODES];

    assign pending = answers.size();

    function automatic int live_nodes();
        if (nodes_reg == 0)
            return 1;
        if (nodes_reg > spsp_pkg::MAX_NODES)
            return spsp_pkg::MAX_NODES;
        return int'(nodes_reg);
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < spsp_pkg::MAX_NODES; i++)
            first_edge[i] = spsp_pkg::MAX_EDGES;
        edges_held = 0;
        dropped = 0;
    endfunction

    function automatic void store_edge(int from_n, int to_n,
                                       logic [spsp_pkg::COST_BITS-1:0] c);
        int n;
        n = live_nodes();
        if (from_n >= n || to_n >= n)
            return;
        if (edges_held >= spsp_pkg::MAX_EDGES)
        begin
            dropped = 1;
            return;
        end
        edge_to[edges_held] = to_n;
        edge_cost_q[edges_held] = c;
        next_edge[edges_held] = first_edge[from_n];
        first_edge[from_n] = edges_held;
        edges_held++;
    endfunction

    function automatic path_answer_t shortest_path(int src, int dst);
        path_answer_t a;
        int n;
        int u;
        int e;
        int t;
        logic [spsp_pkg::DIST_W:0] sum;
        logic [spsp_pkg::DIST_W-1:0] d;
        n = live_nodes();
        a.distance = spsp_pkg::UNREACHED_DISTANCE;
        a.reachable = 0;
        a.full = dropped;
        if (src >= n || dst >= n)
            return a;
        for (int i = 0; i < n; i++)
        begin
            best[i] = 0;
            done[i] = 0;
            seen[i] = 0;
        end
        seen[src] = 1;
        forever
        begin
            u = n;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done[i] && (u == n || best[i] < best[u]))
                    u = i;
            if (u == n)
                break;
            done[u] = 1;
            e = first_edge[u];
            while (e < edges_held)
            begin
                t = edge_to[e];
                if (t < n && !done[t])
                begin
                    sum = {1'b0, best[u]} + edge_cost_q[e];
                    d = sum[spsp_pkg::DIST_W] ? spsp_pkg::DIST_MAX
                                              : sum[spsp_pkg::DIST_W-1:0];
                    if (!seen[t] || d < best[t])
                    begin
                        seen[t] = 1;
                        best[t] = d;
                    end
                end
                e = next_edge[e];
            end
        end
        if (seen[dst])
        begin
            a.distance = best[dst];
            a.reachable = 1;
        end
        return a;
    endfunction

    task automatic report(string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        nodes_reg = spsp_pkg::MAX_NODES;
        wipe_graph();
    end

    always @(posedge clk)
    begin
        path_answer_t want;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                nodes_reg = cfg.node_count;
            if (req.valid && req.ready)
            begin
                case (req.action)
                    spsp_pkg::ACT_CLEAR: wipe_graph();
                    spsp_pkg::ACT_ADD:
                        store_edge(req.from_node, req.to_node, req.edge_cost);
                    spsp_pkg::ACT_QUERY:
                        answers.insert(answers.size(),
                                       shortest_path(req.from_node, req.to_node));
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (answers.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    want = answers.pop_front();
                    if (rsp.distance !== want.distance)
                        report($sformatf("distance %0h, want %0h", rsp.distance,
                                         want.distance));
                    if (rsp.reachable !== want.reachable)
                        report($sformatf("reachable %b, want %b", rsp.reachable,
                                         want.reachable));
                    if (rsp.edge_store_full !== want.full)
                        report($sformatf("edge_store_full %b, want %b",
                                         rsp.edge_store_full, want.full));
                end
            end
        end
    end
endmodule

### bench/single_pair_shortest_path_tb.sv
module single_pair_shortest_path_tb;

    localparam int STALL_LIMIT = 300000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles;
    bit   calm;
    int   hold;
    int   n_live;

    spsp_cfg_if cfg ();
    spsp_req_if req ();
    spsp_rsp_if rsp ();

    single_pair_shortest_path dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    spsp_path_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // result side stalls
    always @(negedge clk)
    begin
        if (hold > 0)
        begin
            rsp.ready = 0;
            hold--;
        end
        else
        begin
            hold = pick_gap();
            rsp.ready = (hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(logic [1:0] act, int from_n, int to_n, int c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req.valid = 0;
            repeat (gap) @(negedge clk);
        end
        req.action = act;
        req.from_node = from_n[spsp_pkg::NODE_AW-1:0];
        req.to_node = to_n[spsp_pkg::NODE_AW-1:0];
        req.edge_cost = c[15:0];
        req.valid = 1;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    // only while the block is idle: adds and clears leave no result to wait on
    task automatic set_nodes(int value);
        req.valid = 0;
        while (pending != 0) @(negedge clk);
        repeat (1200) @(negedge clk);
        cfg.node_count = value[spsp_pkg::CNT_W-1:0];
        cfg.valid = 1;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid = 0;
        if (value == 0)
            n_live = 1;
        else if (value > spsp_pkg::MAX_NODES)
            n_live = spsp_pkg::MAX_NODES;
        else
            n_live = value;
    endtask

    task automatic random_beat();
        int r;
        int a;
        int b;
        r = $urandom_range(0, 99);
        a = $urandom_range(0, n_live - 1);
        b = $urandom_range(0, n_live - 1);
        if (r < 50)
            send(spsp_pkg::ACT_ADD, a, b, $urandom_range(0, 65535));
        else if (r < 55)
            send(spsp_pkg::ACT_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 $urandom_range(0, 65535));
        else if (r < 85)
            send(spsp_pkg::ACT_QUERY, a, b, $urandom_range(0, 65535));
        else if (r < 90)
            send(spsp_pkg::ACT_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        else if (r < 95)
        begin
            // short chain then a query across it
            send(spsp_pkg::ACT_ADD, a, b, $urandom_range(0, 300));
            send(spsp_pkg::ACT_ADD, b, (b + 1) % n_live, $urandom_range(0, 300));
            send(spsp_pkg::ACT_QUERY, a, (b + 1) % n_live, 0);
        end
        else if (r < 98)
            send(spsp_pkg::ACT_CLEAR, a, b, $urandom_range(0, 65535));
        else
            send(spsp_pkg::ACT_SPARE, a, b, $urandom_range(0, 65535));
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        hold = 0;
        calm = 0;
        idle_cycles = 0;
        n_live = spsp_pkg::MAX_NODES;
        rsp.ready = 0;
        req.valid = 0;
        req.action = spsp_pkg::ACT_CLEAR;
        req.from_node = '0;
        req.to_node = '0;
        req.edge_cost = '0;
        cfg.valid = 0;
        cfg.node_count = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_nodes(8);
        send(spsp_pkg::ACT_QUERY, 0, 0, 0);
        send(spsp_pkg::ACT_QUERY, 0, 1, 0);
        send(spsp_pkg::ACT_ADD, 0, 1, 0);
        send(spsp_pkg::ACT_ADD, 1, 2, 65535);
        send(spsp_pkg::ACT_ADD, 0, 2, 65535);
        send(spsp_pkg::ACT_ADD, 2, 7, 3);
        send(spsp_pkg::ACT_ADD, 1023, 0, 5);
        send(spsp_pkg::ACT_ADD, 0, 1023, 5);
        send(spsp_pkg::ACT_SPARE, 1023, 1023, 65535);
        send(spsp_pkg::ACT_QUERY, 0, 7, 0);
        send(spsp_pkg::ACT_QUERY, 1023, 0, 0);
        send(spsp_pkg::ACT_QUERY, 0, 1023, 0);
        send(spsp_pkg::ACT_QUERY, 7, 0, 0);
        set_nodes(6);
        // edge into node 7 now points outside the graph
        send(spsp_pkg::ACT_QUERY, 0, 2, 0);
        send(spsp_pkg::ACT_QUERY, 0, 5, 0);
        send(spsp_pkg::ACT_CLEAR, 0, 0, 0);
        send(spsp_pkg::ACT_QUERY, 0, 1, 0);
        set_nodes(0);
        send(spsp_pkg::ACT_QUERY, 0, 0, 0);
        send(spsp_pkg::ACT_QUERY, 0, 1, 0);
        set_nodes(1);
        send(spsp_pkg::ACT_ADD, 0, 0, 9);
        send(spsp_pkg::ACT_QUERY, 0, 0, 0);
        set_nodes(2047);
        send(spsp_pkg::ACT_ADD, 1023, 0, 65535);
        send(spsp_pkg::ACT_ADD, 0, 512, 40000);
        send(spsp_pkg::ACT_QUERY, 1023, 512, 0);
        send(spsp_pkg::ACT_QUERY, 512, 1023, 0);
        set_nodes(spsp_pkg::MAX_NODES);
        send(spsp_pkg::ACT_QUERY, 1023, 1023, 0);

        // back to back adds and queries on a two node graph
        set_nodes(2);
        send(spsp_pkg::ACT_CLEAR, 0, 0, 0);
        calm = 1;
        for (int i = 0; i < 6; i++)
            send(spsp_pkg::ACT_ADD, i % 2, (i + 1) % 2, $urandom_range(0, 65535));
        send(spsp_pkg::ACT_QUERY, 0, 1, 0);
        send(spsp_pkg::ACT_QUERY, 1, 1, 0);
        calm = 0;
        // hold off until the results have drained
        req.valid = 0;
        while (pending != 0) @(negedge clk);
        send(spsp_pkg::ACT_CLEAR, 0, 0, 0);
        send(spsp_pkg::ACT_QUERY, 0, 1, 0);

        for (int p = 0; p < 5; p++)
        begin
            if (p == 4)
                set_nodes(spsp_pkg::MAX_NODES);
            else
                set_nodes($urandom_range(3, 24));
            calm = (p == 2);
            send(spsp_pkg::ACT_CLEAR, 0, 0, 0);
            for (int i = 0; i < 16; i++)
                random_beat();
        end
        calm = 0;
        req.valid = 0;

        while (pending != 0) @(negedge clk);
        repeat (2000) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### sim.f
hdl/spsp_pkg.sv
hdl/spsp_if.sv
hdl/spsp_graph_store.sv
hdl/spsp_node_table.sv
hdl/single_pair_shortest_path.sv
bench/spsp_path_checker.sv
bench/single_pair_shortest_path_tb.sv
